@@ hdl/cli_pkg.sv @@
package cli_pkg;

  // Tap count and weight format (Q2.14).
  localparam int NUM_TAPS    = 4;
  localparam int WEIGHT_W    = 16;
  localparam int WEIGHT_FRAC = 14;

  // The position is brought to this many fraction bits before the weights are derived.
  localparam int POS_W = 16;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [NUM_TAPS-1:0] tap_weights_t;

  // Weights for t = 0: the nearer preceding row passes straight through.
  localparam tap_weights_t RESET_WEIGHTS = {16'sd0, 16'sd0, 16'sd16384, 16'sd0};

  // Weight generator sequencer.
  typedef enum logic [1:0] {
    WG_IDLE,
    WG_MUL,
    WG_ROUND
  } wg_state_t;

  // Products formed on the shared multiplier, in issue order.
  typedef enum logic [2:0] {
    MS_TT,
    MS_UU,
    MS_TTT,
    MS_UUU,
    MS_TUU,
    MS_UTT
  } mul_step_t;

  // Status handed from the weight generator to the rest of the block.
  typedef struct packed {
    logic         busy;
    tap_weights_t weights;
  } wg_status_t;

endpackage

@@ hdl/cli_weight_gen.sv @@
module cli_weight_gen (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cli_pkg::POS_W-1:0] position,
  output cli_pkg::wg_status_t       status
);
  import cli_pkg::*;

  // Numerators are scaled by 2^(3*POS_W+2); the weight keeps WEIGHT_FRAC fraction bits.
  localparam int NUM_W       = 3 * POS_W + 8;
  localparam int ROUND_SHIFT = 3 * POS_W + 2 - WEIGHT_FRAC;
  localparam int MUL_A_W     = 2 * POS_W + 1;
  localparam int MUL_B_W     = POS_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  wg_state_t            state, state_next;
  mul_step_t            step, step_next;
  logic [POS_W-1:0]     t_val;
  logic [POS_W:0]       u_val;
  logic [2*POS_W-1:0]   t2;
  logic [2*POS_W:0]     u2;
  logic [3*POS_W-1:0]   t3;
  logic [3*POS_W:0]     u3;
  logic [3*POS_W-1:0]   tu2;
  logic [3*POS_W-1:0]   ut2;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    product;
  tap_weights_t         weights;
  tap_weights_t         weights_next;

  // Round half up: floor((n + 2^(ROUND_SHIFT-1)) / 2^ROUND_SHIFT).
  function automatic weight_t round_weight(input logic signed [NUM_W-1:0] n);
    logic signed [NUM_W-1:0] biased;
    biased = n + (NUM_W'(1) <<< (ROUND_SHIFT - 1));
    return biased[ROUND_SHIFT +: WEIGHT_W];
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    case (step)
      MS_TT: begin
        mul_a = MUL_A_W'(t_val);
        mul_b = MUL_B_W'(t_val);
      end
      MS_UU: begin
        mul_a = MUL_A_W'(u_val);
        mul_b = u_val;
      end
      MS_TTT: begin
        mul_a = MUL_A_W'(t2);
        mul_b = MUL_B_W'(t_val);
      end
      MS_UUU: begin
        mul_a = u2;
        mul_b = u_val;
      end
      MS_TUU: begin
        mul_a = u2;
        mul_b = MUL_B_W'(t_val);
      end
      MS_UTT: begin
        mul_a = MUL_A_W'(t2);
        mul_b = u_val;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // Kernel numerators from the stored products, then rounding to Q2.14.
  always_comb begin
    logic signed [NUM_W-1:0] e_t2, e_u2, e_t3, e_u3, e_tu2, e_ut2, one_x4;
    e_t2   = NUM_W'(t2);
    e_u2   = NUM_W'(u2);
    e_t3   = NUM_W'(t3);
    e_u3   = NUM_W'(u3);
    e_tu2  = NUM_W'(tu2);
    e_ut2  = NUM_W'(ut2);
    one_x4 = NUM_W'(1) <<< (3 * POS_W + 2);
    weights_next[0] = round_weight(-(e_tu2 + (e_tu2 <<< 1)));
    weights_next[1] = round_weight(one_x4 - ((e_t2 <<< (POS_W + 3)) + (e_t2 <<< POS_W))
                                   + ((e_t3 <<< 2) + e_t3));
    weights_next[2] = round_weight(one_x4 - ((e_u2 <<< (POS_W + 3)) + (e_u2 <<< POS_W))
                                   + ((e_u3 <<< 2) + e_u3));
    weights_next[3] = round_weight(-(e_ut2 + (e_ut2 <<< 1)));
  end

  // Next state: six multiplies, then a rounding step.
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      WG_IDLE: begin
        if (start) begin
          state_next = WG_MUL;
          step_next  = MS_TT;
        end
      end
      WG_MUL: begin
        if (step == MS_UTT) begin
          state_next = WG_ROUND;
        end else begin
          step_next = mul_step_t'(step + 3'd1);
        end
      end
      WG_ROUND: begin
        state_next = WG_IDLE;
      end
      default: begin
        state_next = WG_IDLE;
      end
    endcase
  end

  // Sequencer and weight registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= WG_IDLE;
      step    <= MS_TT;
      weights <= RESET_WEIGHTS;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (state == WG_ROUND) begin
        weights <= weights_next;
      end
    end
  end

  // Position capture and product registers.
  always_ff @(posedge clk) begin
    if (state == WG_IDLE && start) begin
      t_val <= position;
      u_val <= (MUL_B_W'(1) << POS_W) - MUL_B_W'(position);
    end
    if (state == WG_MUL) begin
      case (step)
        MS_TT:   t2  <= product[2*POS_W-1:0];
        MS_UU:   u2  <= product[2*POS_W:0];
        MS_TTT:  t3  <= product[3*POS_W-1:0];
        MS_UUU:  u3  <= product[3*POS_W:0];
        MS_TUU:  tu2 <= product[3*POS_W-1:0];
        MS_UTT:  ut2 <= product[3*POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.busy    = (state != WG_IDLE);
  assign status.weights = weights;

endmodule

@@ hdl/cli_filter.sv @@
module cli_filter #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [cli_pkg::NUM_TAPS*SAMPLE_BITS-1:0]  in_data,
  input  logic                                      in_last,
  input  cli_pkg::tap_weights_t                     weights,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [SAMPLE_BITS-1:0]                    out_value,
  output logic                                      out_last,
  output logic                                      out_sat
);
  import cli_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + WEIGHT_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W - WEIGHT_FRAC;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (WEIGHT_FRAC - 1);
  localparam logic signed [RND_W-1:0] SAT_MAX =
    RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SAT_MIN = RND_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_smp [NUM_TAPS];
  logic                          s1_last;
  logic                          p_valid;
  logic signed [PROD_W-1:0]      p_prod [NUM_TAPS];
  logic signed [PROD_W-1:0]      prod_next [NUM_TAPS];
  logic                          p_last;
  logic                          out_open;
  logic                          p_open;
  logic signed [ACC_W-1:0]       acc_sum;
  logic signed [ACC_W-1:0]       acc_bias;
  logic signed [RND_W-1:0]       rnd;
  logic                          sat_hi;
  logic                          sat_lo;
  logic [SAMPLE_BITS-1:0]        value_next;

  // Each stage takes a new item when it is empty or its item moves on.
  assign out_open = !out_valid || out_ready;
  assign p_open   = !p_valid || out_open;
  assign in_ready = !s1_valid || p_open;

  // One multiplier per tap.
  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      prod_next[k] = s1_smp[k] * $signed(weights[k]);
    end
  end

  // Sum, round half up to the sample format and clip.
  always_comb begin
    acc_sum = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      acc_sum = acc_sum + ACC_W'(p_prod[k]);
    end
    acc_bias = acc_sum + ROUND_BIAS;
    rnd      = $signed(acc_bias[ACC_W-1:WEIGHT_FRAC]);
    sat_hi   = (rnd > SAT_MAX);
    sat_lo   = (rnd < SAT_MIN);
    if (sat_hi) begin
      value_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (sat_lo) begin
      value_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      value_next = rnd[SAMPLE_BITS-1:0];
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (p_open) begin
        p_valid <= s1_valid;
      end
      if (out_open) begin
        out_valid <= p_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        s1_smp[k] <= $signed(in_data[k*SAMPLE_BITS +: SAMPLE_BITS]);
      end
      s1_last <= in_last;
    end
    if (p_open && s1_valid) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        p_prod[k] <= prod_next[k];
      end
      p_last <= s1_last;
    end
    if (out_open && p_valid) begin
      out_value <= value_next;
      out_last  <= p_last;
      out_sat   <= sat_hi || sat_lo;
    end
  end

endmodule

@@ hdl/cubic_line_interpolator.sv @@
// Vertical bicubic interpolator, Keys kernel with a = -0.75.
// Configuration: one write channel (cfg_valid, cfg_ready, cfg_data) carries the
// fractional position t = cfg_data / 2^POSITION_BITS. After a write transfer the
// four Q2.14 tap weights are derived on one shared 33x17 multiplier: six products
// and a rounding step, during which cfg_ready and s_axis_tready stay low.
// Input: s_axis carries one element of each of four consecutive rows in tdata and
// the end-of-line mark in tlast. Output: m_axis carries the rounded, saturated Q8.8
// sum in tdata, the end-of-line mark in tlast and the saturation flag in tuser.
// Throughput is one item per clock while m_axis is ready and no weights are being
// derived. Each result passes the input, product and result registers before it is
// presented on m_axis. When the receiver stalls, the result register holds its item
// and the stages behind it keep filling until all three are full; only then does
// s_axis_tready drop. Reset clears every stage and loads the t = 0 weights 0, 1, 0,
// 0, so items sent before any configuration pass the nearer preceding row through.
module cubic_line_interpolator #(
  parameter int SAMPLE_BITS   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_valid,
  output logic                                            cfg_ready,
  input  logic [POSITION_BITS-1:0]                        cfg_data,
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  // sample_a, sample_b, sample_c, sample_d, zero padding
  input  logic [((cli_pkg::NUM_TAPS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                            s_axis_tlast,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // interp_value, zero padding
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]                m_axis_tdata,
  output logic                                            m_axis_tlast,
  // saturated
  output logic                                            m_axis_tuser
);
  import cli_pkg::*;

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

  wg_status_t             wg_status;
  logic [POS_W-1:0]       position;
  logic                   filt_in_ready;
  logic [SAMPLE_BITS-1:0] interp_value;

  // Bring the position to the fixed internal fraction width.
  if (POSITION_BITS >= POS_W) begin : g_pos_trunc
    assign position = cfg_data[POSITION_BITS-1 -: POS_W];
  end else begin : g_pos_pad
    assign position = {cfg_data, {(POS_W-POSITION_BITS){1'b0}}};
  end

  assign cfg_ready = !wg_status.busy;

  cli_weight_gen u_weight_gen (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_valid && cfg_ready),
    .position (position),
    .status   (wg_status)
  );

  // Items wait while the weights are being derived.
  assign s_axis_tready = filt_in_ready && !wg_status.busy;

  cli_filter #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_filter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid && !wg_status.busy),
    .in_ready  (filt_in_ready),
    .in_data   (s_axis_tdata[NUM_TAPS*SAMPLE_BITS-1:0]),
    .in_last   (s_axis_tlast),
    .weights   (wg_status.weights),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (interp_value),
    .out_last  (m_axis_tlast),
    .out_sat   (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'(interp_value);

endmodule

@@ hdl/cli_port_checker.sv @@
module cli_port_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             m_axis_tuser
);

  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // A stalled result keeps its payload until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled result changed before its transfer");

  // A position write blocks both channels while the weights are derived.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !cfg_ready && !s_axis_tready)
    else $error("block took a transfer while deriving weights");

  // A flagged result sits at one of the two bounds.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[SAMPLE_BITS-1:0] == SAT_MAX) ||
      (m_axis_tdata[SAMPLE_BITS-1:0] == SAT_MIN))
    else $error("saturation flag set on an unclipped result");

  // Reset leaves no result pending and the configuration port open.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && cfg_ready)
    else $error("block not empty after reset");

endmodule

bind cubic_line_interpolator cli_port_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_port_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

@@ sim/tb.sv @@
// Sample format used by the interpolation predictor.
typedef logic signed [15:0] sample_t;

// One output element of the interpolator.
typedef struct packed {
  logic signed [15:0] value;
  logic               last;
  logic               sat;
} interp_result_t;

// Tracks the current tap weights and the results still owed by the block.
class cubic_predictor;
  cli_pkg::weight_t taps[cli_pkg::NUM_TAPS];
  interp_result_t   pending_results[$];
  int unsigned      mismatches;

  function new();
    taps[0] = '0;
    taps[1] = cli_pkg::weight_t'(1 << cli_pkg::WEIGHT_FRAC);
    taps[2] = '0;
    taps[3] = '0;
    mismatches = 0;
  endfunction

  // Round a value with 36 extra fraction bits half up to Q2.14.
  function longint round_to_q14(longint n);
    return (n + (longint'(1) <<< 35)) >>> 36;
  endfunction

  // Derive the Keys kernel taps (a = -0.75) for t = pos / 2^16, kept exact
  // in units of 2^-50 before rounding.
  function void set_position(logic [15:0] pos);
    longint t, u, s, s3;
    t  = longint'(pos);
    s  = 65536;
    u  = s - t;
    s3 = s * s * s;
    taps[0] = cli_pkg::weight_t'(round_to_q14(-3 * t * u * u));
    taps[1] = cli_pkg::weight_t'(round_to_q14(4 * s3 - 9 * t * t * s + 5 * t * t * t));
    taps[2] = cli_pkg::weight_t'(round_to_q14(4 * s3 - 9 * u * u * s + 5 * u * u * u));
    taps[3] = cli_pkg::weight_t'(round_to_q14(-3 * u * t * t));
  endfunction

  // Compute the result of one accepted input transfer and queue it.
  function void note_item(sample_t a, sample_t b, sample_t c, sample_t d, logic last);
    longint         acc;
    longint         sum;
    interp_result_t res;
    acc = longint'(a) * longint'(taps[0]) + longint'(b) * longint'(taps[1]) +
          longint'(c) * longint'(taps[2]) + longint'(d) * longint'(taps[3]);
    // Drop 14 of the 22 fraction bits with half-up rounding, then clip.
    sum = (acc + 8192) >>> 14;
    res.sat = 1'b0;
    if (sum > 32767) begin
      sum = 32767;
      res.sat = 1'b1;
    end
    if (sum < -32768) begin
      sum = -32768;
      res.sat = 1'b1;
    end
    res.value = sum[15:0];
    res.last  = last;
    pending_results.push_back(res);
  endfunction

  // Compare one output transfer with the oldest queued result.
  function void check_output(logic [15:0] value, logic last, logic sat);
    interp_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected output value=%0d last=%0b sat=%0b",
               $time, $signed(value), last, sat);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (want.value !== value) begin
      $display("%0t: interp_value expected %0d actual %0d",
               $time, want.value, $signed(value));
      mismatches++;
    end
    if (want.last !== last) begin
      $display("%0t: last_out expected %0b actual %0b", $time, want.last, last);
      mismatches++;
    end
    if (want.sat !== sat) begin
      $display("%0t: saturated expected %0b actual %0b", $time, want.sat, sat);
      mismatches++;
    end
  endfunction
endclass

module tb;

  typedef enum int {
    IDLE_NONE,
    IDLE_SOURCE,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;

  cubic_predictor line_model = new();

  cubic_line_interpolator DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock, period 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output side: check each transfer, then pick the ready level for the next edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      line_model.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #(8 * 400000);
    $display("tb failed");
    $finish;
  end

  function automatic sample_t pick_sample();
    sample_t s;
    case ($urandom_range(0, 5))
      0, 1: s = sample_t'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: s = 16'sh7FFF;
          1: s = 16'sh8000;
          2: s = 16'sh0000;
          default: s = 16'shFFFF;
        endcase
      end
      3: s = sample_t'($urandom_range(0, 511)) - 16'sd256;
      default: s = sample_t'($urandom_range(0, 32767));
    endcase
    return s;
  endfunction

  // Present one input element and hold it until the transfer completes.
  task automatic send_item(input sample_t a, input sample_t b, input sample_t c,
                           input sample_t d, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, c, b, a};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    line_model.note_item(a, b, c, d, last);
  endtask

  // Stop sending and wait until every queued result has come out.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (line_model.pending_results.size() != 0);
  endtask

  // Write the fractional position; the block must be idle.
  task automatic write_position(input logic [15:0] pos);
    cfg_valid <= 1'b1;
    cfg_data  <= pos;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    line_model.set_position(pos);
  endtask

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      IDLE_SOURCE: begin
        src_idle_pct  = 61;
        sink_idle_pct = 0;
      end
      IDLE_SINK: begin
        src_idle_pct  = 0;
        sink_idle_pct = 61;
      end
      default: begin
        src_idle_pct  = 9;
        sink_idle_pct = 9;
      end
    endcase
  endtask

  initial begin
    int          phase;
    int          n;
    logic [15:0] pos;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Before any write, the reset weights pass the nearer preceding row through.
    send_item(16'sd1, 16'sh7FFF, -16'sd1, 16'sh8000, 1'b0);
    send_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_item(pick_sample(), 16'sd0, pick_sample(), pick_sample(), 1'b0);
    send_item(pick_sample(), 16'sd12345, pick_sample(), pick_sample(), 1'b1);
    wait_results_done();

    // Midpoint: extremes and saturation in both directions.
    write_position(16'h8000);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_item(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
    send_item(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0);
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_item(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0);
    send_item(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b1);
    send_item(16'sd256, 16'sd512, 16'sd768, 16'sd1024, 1'b0);
    wait_results_done();

    // Largest position: weight almost entirely on the nearer following row.
    write_position(16'hFFFF);
    send_item(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
    send_item(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1);
    send_item(16'sd100, 16'sd200, 16'sd300, 16'sd400, 1'b0);
    wait_results_done();

    // Smallest nonzero position.
    write_position(16'h0001);
    send_item(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
    send_item(16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b1);
    send_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0);
    wait_results_done();

    // Random lines, one position and one idling pattern per phase.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: pos = 16'h0000;
        1: pos = 16'hFFFF;
        2: pos = 16'h4000;
        3: pos = 16'hC000;
        default: pos = 16'($urandom);
      endcase
      write_position(pos);
      set_idle_mode(idle_mode_e'(phase % 4));
      for (n = 0; n < 154; n++) begin
        // Let the block empty completely once in mid-stream.
        if (phase == 5 && n == 77)
          wait_results_done();
        send_item(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                  ($urandom_range(0, 15) == 0));
      end
      wait_results_done();
    end

    // Any stray output after the last result would show up here.
    set_idle_mode(IDLE_NONE);
    repeat (16) @(posedge clk);
    if (line_model.mismatches == 0 && line_model.pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
